FILE: rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants of the token completion scoreboard.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned TokenW = 64;
  localparam int unsigned StatW  = 2;

  // Input item: command, resource token, frame token (lowest bit first)
  localparam int unsigned InBits  = CmdW + 2 * TokenW;
  localparam int unsigned InDataW = ((InBits + 7) / 8) * 8;

  // Result item: status, bad token field, is_ready (lowest bit first)
  localparam int unsigned OutBits  = StatW + 2;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_SCHEDULE = 3'd0,
    CMD_COMPLETE = 3'd1,
    CMD_FAIL     = 3'd2,
    CMD_READY    = 3'd3,
    CMD_RETIRE   = 3'd4,
    CMD_CLEAR    = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_STALE   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef logic [TokenW-1:0] token_t;

  typedef struct packed {
    logic    is_ready;
    logic    bad_token_field;
    status_e status;
  } result_t;

endpackage

FILE: rtl/token_completion_scoreboard_core.sv
// ----------------------------------------------------------------------------
// token_completion_scoreboard_core
// Associative scoreboard of resource tokens with frame completion marks.
// ----------------------------------------------------------------------------
// The block takes command items and returns exactly one result item for
// each, in order. An accepted item lands in an input register; while it
// sits there its 64-bit resource token is compared against every slot of
// the register table in parallel, and once the output register is free the
// slot is updated and the result is captured in the output register.
// Throughput is one item per cycle as long as the output side takes
// results. The parallel key compare plus the lowest-free-slot pick over
// TABLE_ENTRIES slots sets the cycle time. After reset the table is empty;
// no clearing pass is needed, a clear-all command is handled like any
// other. Scheduling a new key into a full table returns status full and
// leaves the table unchanged; zero tokens on schedule or complete return
// status invalid with the offending field named.
module token_completion_scoreboard_core
  import tcs_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: [2:0] command, [66:3] resource key, [130:67] frame generation, rest 0
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tdata: [1:0] status, [2] bad_token_field, [3] is_ready, rest 0
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata
);

  // Input register
  logic   in_vld_q;
  logic   [CmdW-1:0] in_cmd_q;
  token_t in_res_q;
  token_t in_frm_q;

  // Output register
  logic    out_vld_q;
  result_t out_q;
  result_t res_d;

  // Slot table
  logic   [TABLE_ENTRIES-1:0] used_q;
  logic   [TABLE_ENTRIES-1:0] done_q;
  token_t key_q   [TABLE_ENTRIES];
  token_t frame_q [TABLE_ENTRIES];

  logic out_free;
  logic fire;

  // Output slot frees when empty or taken this cycle
  assign out_free      = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q <= s_axis_tdata[CmdW-1:0];
      in_res_q <= s_axis_tdata[CmdW +: TokenW];
      in_frm_q <= s_axis_tdata[CmdW+TokenW +: TokenW];
    end
  end

  // --------------------------------------------------------------------------
  // Lookup and update decision
  // --------------------------------------------------------------------------
  logic [TABLE_ENTRIES-1:0] hit_vec;    // used slot holding the key (one-hot)
  logic [TABLE_ENTRIES-1:0] match_vec;  // hit and frame equal
  logic [TABLE_ENTRIES-1:0] free_vec;
  logic [TABLE_ENTRIES-1:0] free_low;   // lowest free slot, one-hot
  logic [TABLE_ENTRIES-1:0] sched_we;   // write key/frame, set used, clear done
  logic [TABLE_ENTRIES-1:0] done_set;
  logic [TABLE_ENTRIES-1:0] done_clr;
  logic [TABLE_ENTRIES-1:0] used_clr;
  logic                     found;
  logic                     matched;
  logic                     res_zero;
  logic                     frm_zero;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i]   = used_q[i] && (key_q[i] == in_res_q);
      match_vec[i] = hit_vec[i] && (frame_q[i] == in_frm_q);
    end
    found    = |hit_vec;
    matched  = |match_vec;
    free_vec = ~used_q;
    free_low = free_vec & (~free_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});
    res_zero = (in_res_q == '0);
    frm_zero = (in_frm_q == '0);

    res_d.status          = ST_OK;
    res_d.bad_token_field = 1'b0;
    res_d.is_ready        = 1'b0;
    sched_we = '0;
    done_set = '0;
    done_clr = '0;
    used_clr = '0;

    case (in_cmd_q)
      CMD_SCHEDULE: begin
        if (res_zero) begin
          res_d.status = ST_INVALID;
        end else if (frm_zero) begin
          res_d.status          = ST_INVALID;
          res_d.bad_token_field = 1'b1;
        end else if (found) begin
          sched_we = hit_vec;
        end else if (|free_vec) begin
          sched_we = free_low;
        end else begin
          res_d.status = ST_FULL;
        end
      end
      CMD_COMPLETE: begin
        if (res_zero) begin
          res_d.status = ST_INVALID;
        end else if (frm_zero) begin
          res_d.status          = ST_INVALID;
          res_d.bad_token_field = 1'b1;
        end else if (!matched) begin
          res_d.status = ST_STALE;
        end else begin
          done_set = match_vec;
        end
      end
      CMD_FAIL: begin
        done_clr = match_vec;
      end
      CMD_READY: begin
        res_d.is_ready = |(match_vec & done_q);
      end
      CMD_RETIRE: begin
        used_clr = hit_vec;
        done_clr = hit_vec;
      end
      CMD_CLEAR: begin
        used_clr = '1;
        done_clr = '1;
      end
      default: begin
        // unknown command: no effect, status ok
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Table update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      done_q <= '0;
    end else if (fire) begin
      used_q <= (used_q & ~used_clr) | sched_we;
      done_q <= (done_q & ~(done_clr | sched_we)) | done_set;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (fire && sched_we[i]) begin
        key_q[i]   <= in_res_q;
        frame_q[i] <= in_frm_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-OutBits){1'b0}}, out_q};

endmodule

FILE: rtl/tcs_checker.sv
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level assertions for the token completion scoreboard.
// ----------------------------------------------------------------------------
module tcs_checker
  import tcs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A positive ready answer comes only with status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[1:0] == ST_OK)
    else $error("is_ready with non-ok status");

  // Bad field is only named on an invalid token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == ST_INVALID)
    else $error("bad_token_field without invalid status");

  // Pad bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:OutBits] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind token_completion_scoreboard_core tcs_checker u_tcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/token_completion_scoreboard_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_completion_scoreboard_core_tb
// Self-checking bench for the token completion scoreboard: commands stream in
// with random gaps, every result is checked in order against a local model of
// the slot table, the output side stalls at random and once for a long spell.
// ----------------------------------------------------------------------------
module token_completion_scoreboard_core_tb;
  import tcs_pkg::*;

  localparam int unsigned TableEntries = 16;
  localparam int ItemTarget  = 1150;
  localparam int CycleLimit  = 200000;
  localparam int MaxGap      = 7;
  localparam int HoldCycles  = 300;   // long output stall, fills the pipe
  localparam int HoldAfter   = 400;   // results seen before the long stall
  localparam int DrainCycles = 8;     // extra wait after the last result
  localparam int KeyPoolSize = 48;
  localparam int HotKeys     = 16;    // keys that lifecycles work on
  localparam int MaxShown    = 40;    // mismatch lines printed at most

  // Command codes the block ignores
  localparam logic [CmdW-1:0] CmdSpareLo = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  localparam token_t TokZero    = '0;
  localparam token_t TokOne     = token_t'(1);
  localparam token_t TokAllOnes = '1;
  localparam token_t TokMsb     = {1'b1, {(TokenW-1){1'b0}}};

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // tdata: [2:0] command, [66:3] resource key, [130:67] frame generation, rest 0
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // tdata: [1:0] status, [2] bad_token_field, [3] is_ready, rest 0
  logic [OutDataW-1:0] m_axis_tdata;

  token_completion_scoreboard_core #(
    .TABLE_ENTRIES(TableEntries)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // One pending answer: the predicted result plus the command for context
  typedef struct {
    result_t         res;
    logic [CmdW-1:0] cmd;
    int              serial;
  } answer_t;

  // --------------------------------------------------------------------------
  // Slot table model and in-order result checker
  // --------------------------------------------------------------------------
  class completion_board;
    logic    slot_used  [TableEntries];
    token_t  slot_key   [TableEntries];
    token_t  slot_frame [TableEntries];
    logic    slot_done  [TableEntries];
    answer_t pending [$];
    int      noted;
    int      checked;
    int      mismatches;
    int      by_status [4];
    int      ready_hits;

    function new();
      for (int i = 0; i < TableEntries; i++) begin
        slot_used[i]  = 1'b0;
        slot_key[i]   = '0;
        slot_frame[i] = '0;
        slot_done[i]  = 1'b0;
      end
      noted = 0;
      checked = 0;
      mismatches = 0;
      ready_hits = 0;
      for (int i = 0; i < 4; i++) by_status[i] = 0;
    endfunction

    // Called on every accepted command: updates the table, queues the answer
    function void note_command(logic [CmdW-1:0] cmd, token_t rsc, token_t frm);
      int      hit;
      int      spot;
      logic    match;
      answer_t want;
      hit = -1;
      spot = -1;
      for (int i = 0; i < TableEntries; i++) begin
        if (hit < 0 && slot_used[i] && slot_key[i] == rsc) hit = i;
        if (spot < 0 && !slot_used[i]) spot = i;
      end
      match = 1'b0;
      if (hit >= 0) match = (slot_frame[hit] == frm);
      want.cmd                 = cmd;
      want.serial              = noted;
      want.res.status          = ST_OK;
      want.res.bad_token_field = 1'b0;
      want.res.is_ready        = 1'b0;
      case (cmd)
        CMD_SCHEDULE: begin
          if (rsc == TokZero) begin
            want.res.status = ST_INVALID;
          end else if (frm == TokZero) begin
            want.res.status          = ST_INVALID;
            want.res.bad_token_field = 1'b1;
          end else begin
            // an existing key is overwritten in place, a new one takes the
            // lowest free slot
            if (hit < 0) hit = spot;
            if (hit < 0) begin
              want.res.status = ST_FULL;
            end else begin
              slot_used[hit]  = 1'b1;
              slot_key[hit]   = rsc;
              slot_frame[hit] = frm;
              slot_done[hit]  = 1'b0;
            end
          end
        end
        CMD_COMPLETE: begin
          if (rsc == TokZero) begin
            want.res.status = ST_INVALID;
          end else if (frm == TokZero) begin
            want.res.status          = ST_INVALID;
            want.res.bad_token_field = 1'b1;
          end else if (!match) begin
            want.res.status = ST_STALE;
          end else begin
            slot_done[hit] = 1'b1;
          end
        end
        CMD_FAIL: begin
          if (match) slot_done[hit] = 1'b0;
        end
        CMD_READY: begin
          if (match) want.res.is_ready = slot_done[hit];
        end
        CMD_RETIRE: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            slot_done[hit] = 1'b0;
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < TableEntries; i++) begin
            slot_used[i] = 1'b0;
            slot_done[i] = 1'b0;
          end
        end
        default: begin
          // spare codes: no effect, plain ok
        end
      endcase
      pending.push_back(want);
      noted++;
    endfunction

    // Called on every accepted result: compares against the oldest answer
    function void check_result(logic [OutDataW-1:0] data);
      result_t                      got;
      logic [OutDataW-OutBits-1:0]  pad;
      answer_t                      want;
      got = result_t'(data[OutBits-1:0]);
      pad = data[OutDataW-1:OutBits];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("%0t: unexpected result, nothing pending: status %0d bad %0b ready %0b",
                   $time, got.status, got.bad_token_field, got.is_ready);
        return;
      end
      want = pending.pop_front();
      checked++;
      by_status[want.res.status]++;
      if (want.res.is_ready) ready_hits++;
      if (got !== want.res || pad !== '0) begin
        mismatches++;
        if (mismatches <= MaxShown) begin
          $write("%0t: item %0d cmd %0d: expected status %0d bad %0b ready %0b,",
                 $time, want.serial, want.cmd, want.res.status,
                 want.res.bad_token_field, want.res.is_ready);
          $display(" got status %0d bad %0b ready %0b pad %h",
                   got.status, got.bad_token_field, got.is_ready, pad);
        end
        if (mismatches == MaxShown)
          $display("%0t: further mismatches counted but not shown", $time);
      end
    endfunction
  endclass

  completion_board board;
  token_t          key_pool [KeyPoolSize];
  bit              calm;          // no random gaps on either side while set
  bit              held_off;      // long output stall has happened
  int              items_sent;
  int              cycle_count;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic token_t rand_token();
    return {$urandom, $urandom};
  endfunction

  // Nonzero frame: mostly wide random, some extremes and small values so
  // that stale and matching frames both come up
  function automatic token_t pick_frame();
    token_t frm;
    case ($urandom_range(0, 7))
      0:       frm = TokAllOnes;
      1:       frm = token_t'($urandom_range(1, 3));
      default: frm = rand_token();
    endcase
    if (frm == TokZero) frm = TokOne;
    return frm;
  endfunction

  function automatic token_t pick_hot_key();
    return key_pool[$urandom_range(0, HotKeys - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one command item per call, random gap first. Entered and left
  // just after a falling edge; tvalid stays high across back-to-back items.
  // --------------------------------------------------------------------------
  task automatic send(logic [CmdW-1:0] cmd, token_t rsc, token_t frm);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - InBits){1'b0}}, frm, rsc, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_command(cmd, rsc, frm);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Well-formed life of one resource: schedule, then completes, fails and
  // ready queries on it, sometimes a retire
  task automatic run_lifecycle();
    token_t key;
    token_t frm;
    int     steps;
    key = pick_hot_key();
    frm = pick_frame();
    steps = $urandom_range(1, 6);
    send(CMD_SCHEDULE, key, frm);
    repeat (steps) begin
      case ($urandom_range(0, 6))
        0, 1:    send(CMD_COMPLETE, key, frm);
        2:       send(CMD_COMPLETE, key, pick_frame());
        3:       send(CMD_FAIL, key, ($urandom_range(0, 3) == 0) ? pick_frame() : frm);
        default: send(CMD_READY, key, frm);
      endcase
    end
    if ($urandom_range(0, 3) == 0) send(CMD_RETIRE, key, frm);
  endtask

  // Burst of schedules over the whole key pool, drives the table toward full
  task automatic run_fill();
    repeat ($urandom_range(4, 20))
      send(CMD_SCHEDULE, key_pool[$urandom_range(0, KeyPoolSize - 1)], pick_frame());
  endtask

  task automatic run_retires();
    repeat ($urandom_range(1, 6))
      send(CMD_RETIRE, key_pool[$urandom_range(0, KeyPoolSize - 1)], pick_frame());
  endtask

  // Anything the fields allow: spare codes, zero tokens, unknown keys
  task automatic run_noise();
    logic [CmdW-1:0] cmd;
    token_t          rsc;
    token_t          frm;
    cmd = CmdW'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0:       rsc = TokZero;
      1:       rsc = rand_token();
      default: rsc = key_pool[$urandom_range(0, KeyPoolSize - 1)];
    endcase
    frm = ($urandom_range(0, 5) == 0) ? TokZero : pick_frame();
    send(cmd, rsc, frm);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    calm          = 1'b0;
    items_sent    = 0;
    board         = new();
    key_pool[0] = TokAllOnes;
    key_pool[1] = TokOne;
    key_pool[2] = TokMsb;
    for (int i = 3; i < KeyPoolSize; i++) begin
      key_pool[i] = rand_token();
      if (key_pool[i] == TokZero) key_pool[i] = token_t'(i);
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero tokens on schedule and complete: resource field reported first
    send(CMD_SCHEDULE, TokZero, token_t'(5));
    send(CMD_SCHEDULE, TokOne, TokZero);
    send(CMD_SCHEDULE, TokZero, TokZero);
    send(CMD_COMPLETE, TokZero, TokOne);
    send(CMD_COMPLETE, TokOne, TokZero);
    // Full-width tokens through complete, fail and ready
    send(CMD_SCHEDULE, TokAllOnes, TokAllOnes);
    send(CMD_READY,    TokAllOnes, TokAllOnes);
    send(CMD_COMPLETE, TokAllOnes, TokOne);        // wrong frame: stale
    send(CMD_COMPLETE, TokAllOnes, TokAllOnes);
    send(CMD_READY,    TokAllOnes, TokAllOnes);
    send(CMD_FAIL,     TokAllOnes, TokOne);        // frame differs: no effect
    send(CMD_READY,    TokAllOnes, TokAllOnes);
    send(CMD_FAIL,     TokAllOnes, TokAllOnes);
    send(CMD_READY,    TokAllOnes, TokAllOnes);
    // Reschedule of a live key drops its done mark
    send(CMD_COMPLETE, TokAllOnes, TokAllOnes);
    send(CMD_SCHEDULE, TokAllOnes, TokMsb);
    send(CMD_COMPLETE, TokAllOnes, TokAllOnes);
    send(CMD_READY,    TokAllOnes, TokMsb);
    send(CMD_COMPLETE, TokMsb, TokOne);            // key not tracked
    // Zero tokens on fail, ready and retire match nothing
    send(CMD_FAIL,     TokZero, TokZero);
    send(CMD_READY,    TokZero, TokZero);
    send(CMD_RETIRE,   TokZero, TokZero);
    send(CmdSpareLo,   TokAllOnes, TokMsb);
    send(CmdSpareHi,   TokZero, TokZero);
    send(CMD_RETIRE,   TokAllOnes, TokZero);
    send(CMD_READY,    TokAllOnes, TokMsb);
    send(CMD_CLEAR,    TokZero, TokZero);

    // Random part: mostly whole lifecycles, with fills to full, retires,
    // rare clears and loose noise
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 11) == 0) calm = ~calm;
      case ($urandom_range(0, 19))
        0, 1:        run_fill();
        2, 3, 4:     run_retires();
        5:           send(CMD_CLEAR, rand_token(), pick_frame());
        6, 7, 8, 9:  run_noise();
        default:     run_lifecycle();
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d items, %0d results: %0d ok, %0d invalid, %0d stale, %0d full",
             items_sent, board.checked, board.by_status[ST_OK], board.by_status[ST_INVALID],
             board.by_status[ST_STALE], board.by_status[ST_FULL]);
    $display("ready answers true: %0d; long output stall of %0d cycles taken: %0b",
             board.ready_hits, HoldCycles, held_off);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random stall per result, one long hold-off so the block
  // backs up and drops s_axis_tready while items keep coming
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall;
    m_axis_tready = 1'b0;
    held_off      = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!held_off && board.checked >= HoldAfter) begin
        held_off = 1'b1;
        stall    = HoldCycles;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Results are checked at the edge where they are taken
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: cycle limit of %0d reached, %0d results still pending",
             $time, CycleLimit, board.pending.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tcs_pkg.sv
rtl/token_completion_scoreboard_core.sv
rtl/tcs_checker.sv
tb/token_completion_scoreboard_core_tb.sv
